[rtl/core/cclc_pkg.sv]
// ----------------------------------------------------------------------------
// cclc_pkg
// Shared types, codes and letter tables for the cheat-code letter codec.
// ----------------------------------------------------------------------------
package cclc_pkg;

  // Operation codes carried on the op input.
  localparam logic OpDecode = 1'b0;
  localparam logic OpEncode = 1'b1;

  // Code lengths reported with each result.
  localparam logic [3:0] CodeLenShort = 4'd6;
  localparam logic [3:0] CodeLenLong  = 4'd8;

  // Packed word layout.
  localparam int unsigned UseCmpBit = 31;

  // One result word of the codec.
  typedef struct packed {
    logic [31:0]     packed_word;
    logic [7:0][7:0] chars;
    logic [3:0]      code_length;
    logic            error;
  } result_t;

  // Letter lookup result: valid flag and the nibble it stands for.
  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } letter_t;

  // Maps an ASCII byte, either case, to its nibble. Invalid bytes give zero.
  function automatic letter_t letter_value(input logic [7:0] c);
    logic [7:0] up;
    letter_t    r;
    up = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
    r.valid  = 1'b1;
    r.nibble = 4'd0;
    case (up)
      "A":     r.nibble = 4'd0;
      "P":     r.nibble = 4'd1;
      "Z":     r.nibble = 4'd2;
      "L":     r.nibble = 4'd3;
      "G":     r.nibble = 4'd4;
      "I":     r.nibble = 4'd5;
      "T":     r.nibble = 4'd6;
      "Y":     r.nibble = 4'd7;
      "E":     r.nibble = 4'd8;
      "O":     r.nibble = 4'd9;
      "X":     r.nibble = 4'd10;
      "U":     r.nibble = 4'd11;
      "K":     r.nibble = 4'd12;
      "S":     r.nibble = 4'd13;
      "V":     r.nibble = 4'd14;
      "N":     r.nibble = 4'd15;
      default: r.valid  = 1'b0;
    endcase
    return r;
  endfunction

  // Maps a nibble to its upper-case letter.
  function automatic logic [7:0] letter_char(input logic [3:0] n);
    logic [7:0] c;
    case (n)
      4'd0:    c = "A";
      4'd1:    c = "P";
      4'd2:    c = "Z";
      4'd3:    c = "L";
      4'd4:    c = "G";
      4'd5:    c = "I";
      4'd6:    c = "T";
      4'd7:    c = "Y";
      4'd8:    c = "E";
      4'd9:    c = "O";
      4'd10:   c = "X";
      4'd11:   c = "U";
      4'd12:   c = "K";
      4'd13:   c = "S";
      4'd14:   c = "V";
      default: c = "N";
    endcase
    return c;
  endfunction

endpackage

[rtl/core/cclc_decode.sv]
// ----------------------------------------------------------------------------
// cclc_decode
// Turns six or eight code letters into the packed address/compare/data word.
// ----------------------------------------------------------------------------
module cclc_decode (
  input  logic [7:0][7:0]          chars_i,
  output cclc_pkg::result_t        result_o
);
  import cclc_pkg::*;

  letter_t [7:0]   lv;
  logic [7:0][3:0] n;
  logic            eight;
  logic            bad;
  logic [14:0]     addr;
  logic [7:0]      data;
  logic [7:0]      cmp;

  // Look up every letter; invalid letters read as nibble zero.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lv[i] = letter_value(chars_i[i]);
      n[i]  = lv[i].nibble;
    end
  end

  // The third letter selects the long form only when it is a valid letter.
  assign eight = lv[2].valid & lv[2].nibble[3];
  assign bad   = ~(&{lv[5].valid, lv[4].valid, lv[3].valid,
                     lv[2].valid, lv[1].valid, lv[0].valid})
               | (eight & ~(lv[6].valid & lv[7].valid));

  // Unscramble the address bits.
  assign addr = {n[3][2:0], n[4][3], n[5][2:0], n[1][3], n[2][2:0], n[3][3], n[4][2:0]};

  // Data byte takes its bit 3 from the eighth letter in long form, else the sixth.
  assign data = eight ? {n[0][3], n[1][2:0], n[7][3], n[0][2:0]}
                      : {n[0][3], n[1][2:0], n[5][3], n[0][2:0]};
  assign cmp  = eight ? {n[6][3], n[7][2:0], n[5][3], n[6][2:0]} : 8'd0;

  // Assemble the result; an error clears the word.
  always_comb begin
    result_o.chars       = '0;
    result_o.code_length = eight ? CodeLenLong : CodeLenShort;
    result_o.error       = bad;
    result_o.packed_word = bad ? 32'd0 : {eight, addr, cmp, data};
  end

endmodule

[rtl/core/cclc_encode.sv]
// ----------------------------------------------------------------------------
// cclc_encode
// Scrambles a packed address/compare/data word into upper-case code letters.
// ----------------------------------------------------------------------------
module cclc_encode (
  input  logic [31:0]              packed_i,
  output cclc_pkg::result_t        result_o
);
  import cclc_pkg::*;

  logic            eight;
  logic [14:0]     a;
  logic [7:0]      d;
  logic [7:0]      c;
  logic [7:0][3:0] n;

  assign eight = packed_i[UseCmpBit];
  assign a     = packed_i[30:16];
  assign c     = packed_i[15:8];
  assign d     = packed_i[7:0];

  // Spread the address, data and compare bits over the nibbles.
  always_comb begin
    n[0] = {d[7], d[2:0]};
    n[1] = {a[7], d[6:4]};
    n[2] = {eight, a[6:4]};
    n[3] = {a[3], a[14:12]};
    n[4] = {a[11], a[2:0]};
    n[5] = eight ? {c[3], a[10:8]} : {d[3], a[10:8]};
    n[6] = {c[7], c[2:0]};
    n[7] = {d[3], c[6:4]};
  end

  // Map nibbles to letters; the short form leaves the last two letters zero.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      result_o.chars[i] = letter_char(n[i]);
    end
    if (!eight) begin
      result_o.chars[6] = 8'd0;
      result_o.chars[7] = 8'd0;
    end
    result_o.packed_word = 32'd0;
    result_o.code_length = eight ? CodeLenLong : CodeLenShort;
    result_o.error       = 1'b0;
  end

endmodule

[rtl/core/cheat_code_letter_codec_core.sv]
// ----------------------------------------------------------------------------
// cheat_code_letter_codec_core
// Converts between six- or eight-letter cheat codes and a packed 32-bit word.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at a rising edge where start is high and busy is low.
//   busy stays low: the codec has no shared unit, so it takes a word every
//   cycle. op_i selects decode (letters to packed word) or encode (packed
//   word to upper-case letters).
//   Each word is captured in an input register, translated by letter lookup
//   and bit permutation, and captured in a result register. The result shows
//   on the output ports for exactly one cycle, marked by done_o. One result
//   leaves per cycle. The receiver cannot stall; it must take the result in
//   the cycle done_o is high.
//   Reset clears the input and result valid flags, so no result appears
//   until a new word is taken; there is no stored state beyond that.
// ----------------------------------------------------------------------------
module cheat_code_letter_codec_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [7:0]  in_char_0_i,
  input  logic [7:0]  in_char_1_i,
  input  logic [7:0]  in_char_2_i,
  input  logic [7:0]  in_char_3_i,
  input  logic [7:0]  in_char_4_i,
  input  logic [7:0]  in_char_5_i,
  input  logic [7:0]  in_char_6_i,
  input  logic [7:0]  in_char_7_i,
  input  logic [31:0] packed_in_i,
  output logic        done_o,
  output logic [31:0] packed_out_o,
  output logic [7:0]  out_char_0_o,
  output logic [7:0]  out_char_1_o,
  output logic [7:0]  out_char_2_o,
  output logic [7:0]  out_char_3_o,
  output logic [7:0]  out_char_4_o,
  output logic [7:0]  out_char_5_o,
  output logic [7:0]  out_char_6_o,
  output logic [7:0]  out_char_7_o,
  output logic [3:0]  code_length_o,
  output logic        error_o
);
  import cclc_pkg::*;

  logic            accept;
  logic            in_valid_q;
  logic            op_q;
  logic [7:0][7:0] chars_q;
  logic [31:0]     packed_q;
  result_t         dec_res;
  result_t         enc_res;
  result_t         res_d;
  result_t         res_q;
  logic            res_valid_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      chars_q  <= {in_char_7_i, in_char_6_i, in_char_5_i, in_char_4_i,
                   in_char_3_i, in_char_2_i, in_char_1_i, in_char_0_i};
      packed_q <= packed_in_i;
    end
  end

  cclc_decode u_decode (
    .chars_i  (chars_q),
    .result_o (dec_res)
  );

  cclc_encode u_encode (
    .packed_i (packed_q),
    .result_o (enc_res)
  );

  // Pick the translation that the operation asks for.
  assign res_d = (op_q == OpEncode) ? enc_res : dec_res;

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  // Drive the result ports.
  assign done_o        = res_valid_q;
  assign packed_out_o  = res_q.packed_word;
  assign out_char_0_o  = res_q.chars[0];
  assign out_char_1_o  = res_q.chars[1];
  assign out_char_2_o  = res_q.chars[2];
  assign out_char_3_o  = res_q.chars[3];
  assign out_char_4_o  = res_q.chars[4];
  assign out_char_5_o  = res_q.chars[5];
  assign out_char_6_o  = res_q.chars[6];
  assign out_char_7_o  = res_q.chars[7];
  assign code_length_o = res_q.code_length;
  assign error_o       = res_q.error;

endmodule

[rtl/core/cclc_checker.sv]
// ----------------------------------------------------------------------------
// cclc_checker
// Port-level checks on the codec's timing and result word shape.
// ----------------------------------------------------------------------------
module cclc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] packed_out_o,
  input logic [7:0]  out_char_6_o,
  input logic [7:0]  out_char_7_o,
  input logic [3:0]  code_length_o,
  input logic        error_o
);

  // Every taken word gives a result, through the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("taken word gave no result two cycles later");

  // A result only follows a taken word.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a taken word");

  // An error result carries a cleared word.
  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && error_o |-> packed_out_o == 32'd0)
    else $error("error result with nonzero word");

  // Short-form results have no compare byte, no use-compare bit and no tail letters.
  a_short_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && code_length_o == 4'd6 |->
      packed_out_o[31] == 1'b0 && packed_out_o[15:8] == 8'd0 &&
      out_char_6_o == 8'd0 && out_char_7_o == 8'd0)
    else $error("six-letter result carries long-form fields");

  // The reported length is six or eight.
  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> code_length_o == 4'd6 || code_length_o == 4'd8)
    else $error("code length is neither six nor eight");

endmodule

bind cheat_code_letter_codec_core cclc_checker u_cclc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .packed_out_o  (packed_out_o),
  .out_char_6_o  (out_char_6_o),
  .out_char_7_o  (out_char_7_o),
  .code_length_o (code_length_o),
  .error_o       (error_o)
);

[tb/sv/tb_cheat_code_letter_codec_core.sv]
// ----------------------------------------------------------------------------
// tb_cheat_code_letter_codec_core
// Self-checking bench for the cheat-code letter codec. Directed and random
// decode and encode words go in through the start/busy handshake. Each word's
// result is predicted in the bench and matched, field by field, against the
// word that done_o marks.
// ----------------------------------------------------------------------------
module tb_cheat_code_letter_codec_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cclc_pkg::*;

  typedef logic [7:0][7:0] letters_t;

  // The sixteen code letters in nibble order, first letter in the top byte.
  localparam logic [127:0] ALPHABET = "APZLGITYEOXUKSVN";

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        op_i;
  logic [7:0]  in_char_0_i, in_char_1_i, in_char_2_i, in_char_3_i;
  logic [7:0]  in_char_4_i, in_char_5_i, in_char_6_i, in_char_7_i;
  logic [31:0] packed_in_i;
  logic        done_o;
  logic [31:0] packed_out_o;
  logic [7:0]  out_char_0_o, out_char_1_o, out_char_2_o, out_char_3_o;
  logic [7:0]  out_char_4_o, out_char_5_o, out_char_6_o, out_char_7_o;
  logic [3:0]  code_length_o;
  logic        error_o;

  result_t     pending_results[$];
  int unsigned idle_pct;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned decode_words, encode_words, long_words, bad_words;

  cheat_code_letter_codec_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .in_char_0_i   (in_char_0_i),
    .in_char_1_i   (in_char_1_i),
    .in_char_2_i   (in_char_2_i),
    .in_char_3_i   (in_char_3_i),
    .in_char_4_i   (in_char_4_i),
    .in_char_5_i   (in_char_5_i),
    .in_char_6_i   (in_char_6_i),
    .in_char_7_i   (in_char_7_i),
    .packed_in_i   (packed_in_i),
    .done_o        (done_o),
    .packed_out_o  (packed_out_o),
    .out_char_0_o  (out_char_0_o),
    .out_char_1_o  (out_char_1_o),
    .out_char_2_o  (out_char_2_o),
    .out_char_3_o  (out_char_3_o),
    .out_char_4_o  (out_char_4_o),
    .out_char_5_o  (out_char_5_o),
    .out_char_6_o  (out_char_6_o),
    .out_char_7_o  (out_char_7_o),
    .code_length_o (code_length_o),
    .error_o       (error_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Upper-case letter for a nibble.
  function automatic logic [7:0] code_letter(input logic [3:0] nib);
    return ALPHABET[127 - 8 * nib -: 8];
  endfunction

  // Looks a byte up in the alphabet, either case; found is low for a bad byte.
  function automatic logic [3:0] letter_nibble(input logic [7:0] c, output logic found);
    logic [7:0] up;
    logic [3:0] nib;
    up    = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    found = 1'b0;
    nib   = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (code_letter(k[3:0]) == up) begin
        found = 1'b1;
        nib   = k[3:0];
      end
    end
    return nib;
  endfunction

  // Gathers one byte from nibbles: lo holds bits 2:0 and 7, mid bit 3, hi bits 6:4.
  function automatic logic [7:0] gather_byte(input logic [3:0] lo, mid, hi);
    return {lo[3], hi[2:0], mid[3], lo[2:0]};
  endfunction

  // Predicts the result word of the codec for one input word.
  function automatic result_t predict_codec(input logic op, input letters_t letters,
                                            input logic [31:0] word);
    result_t       r;
    logic [3:0]    nib [8];
    logic          found;
    logic          bad;
    logic          eight;
    logic [3:0]    v;
    logic [14:0]   addr;
    logic [7:0]    data_b, cmp_b;
    int unsigned   len;
    r     = '0;
    bad   = 1'b0;
    len   = 6;
    for (int i = 0; i < 8; i++) nib[i] = 4'd0;
    if (op == OpDecode) begin
      for (int i = 0; i < 8; i++) begin
        if (i < len) begin
          v = letter_nibble(letters[i], found);
          if (!found) begin
            bad = 1'b1;
          end else begin
            nib[i] = v;
            if (i == 2 && v[3]) len = 8;
          end
        end
      end
      r.code_length = (len == 8) ? CodeLenLong : CodeLenShort;
      r.error       = bad;
      if (!bad) begin
        addr = {nib[3][2:0], nib[4][3], nib[5][2:0], nib[1][3], nib[2][2:0],
                nib[3][3], nib[4][2:0]};
        r.packed_word[30:16] = addr;
        if (len == 8) begin
          r.packed_word[7:0]      = gather_byte(nib[0], nib[7], nib[1]);
          r.packed_word[15:8]     = gather_byte(nib[6], nib[5], nib[7]);
          r.packed_word[UseCmpBit] = 1'b1;
        end else begin
          r.packed_word[7:0] = gather_byte(nib[0], nib[5], nib[1]);
        end
      end
    end else begin
      eight  = word[UseCmpBit];
      addr   = word[30:16];
      data_b = word[7:0];
      cmp_b  = word[15:8];
      // Scatter the address over the middle letters.
      nib[4] = {addr[11], addr[2:0]};
      nib[3] = {addr[3], addr[14:12]};
      nib[2] = {eight, addr[6:4]};
      nib[1] = {addr[7], data_b[6:4]};
      nib[0] = {data_b[7], data_b[2:0]};
      if (eight) begin
        nib[7] = {data_b[3], cmp_b[6:4]};
        nib[6] = {cmp_b[7], cmp_b[2:0]};
        nib[5] = {cmp_b[3], addr[10:8]};
      end else begin
        nib[5] = {data_b[3], addr[10:8]};
      end
      for (int i = 0; i < 8; i++) begin
        if (i < 6 || eight) r.chars[i] = code_letter(nib[i]);
      end
      r.code_length = eight ? CodeLenLong : CodeLenShort;
    end
    return r;
  endfunction

  // Turns text into a letter vector, padding with zero bytes.
  function automatic letters_t text_letters(input string s);
    letters_t l;
    l = '0;
    for (int i = 0; i < 8 && i < s.len(); i++) l[i] = s[i];
    return l;
  endfunction

  // A valid letter for a nibble, in random case.
  function automatic logic [7:0] any_case_letter(input logic [3:0] nib);
    return code_letter(nib) + ($urandom_range(1) ? 8'd32 : 8'd0);
  endfunction

  // Sends one word, with an occasional random gap ahead of it. Starts and
  // ends at a falling edge; start stays high between back-to-back words.
  task automatic send_word(input logic op, input letters_t letters, input logic [31:0] word);
    result_t expd;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start       = 1'b1;
    op_i        = op;
    in_char_0_i = letters[0];
    in_char_1_i = letters[1];
    in_char_2_i = letters[2];
    in_char_3_i = letters[3];
    in_char_4_i = letters[4];
    in_char_5_i = letters[5];
    in_char_6_i = letters[6];
    in_char_7_i = letters[7];
    packed_in_i = word;
    expd        = predict_codec(op, letters, word);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(expd);
    if (op == OpDecode) decode_words++;
    else encode_words++;
    if (expd.code_length == CodeLenLong) long_words++;
    if (expd.error) bad_words++;
    @(negedge clk_i);
  endtask

  // Holds off the sender until every expected result is back.
  task automatic wait_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Decode corner cases: extremes, both cases, bad letters and ignored letters.
  task automatic test_decode_directed();
    letters_t l;
    l = text_letters("AAAAAA");
    l[6] = 8'hFF;
    send_word(OpDecode, l, 32'hFFFF_FFFF);
    send_word(OpDecode, text_letters("NNNNNNNN"), '0);
    send_word(OpDecode, text_letters("nnnnnnnn"), '0);
    send_word(OpDecode, text_letters("pEtOxUkS"), '0);
    send_word(OpDecode, text_letters("GITYEO"), '0);
    // Bad first letter.
    l = text_letters("APZLGI");
    l[0] = 8'h00;
    send_word(OpDecode, l, '0);
    // Bad third letter: no long form, length stays six.
    l = text_letters("APELGI");
    l[2] = 8'hFF;
    send_word(OpDecode, l, '0);
    // Long form with a bad last letter.
    l = text_letters("AAEAAAA@");
    send_word(OpDecode, l, '0);
    // Short form ignores junk in the last two letters.
    l = text_letters("AAAAAA[{");
    send_word(OpDecode, l, '0);
    // Bytes just outside the letter ranges, and a letter with bit 7 set.
    l = text_letters("A`AA{A");
    send_word(OpDecode, l, '0);
    l = text_letters("AAAAAA");
    l[4] = 8'hE1;
    send_word(OpDecode, l, '0);
  endtask

  // Encode corner cases: all-zero, all-one and the two forms.
  task automatic test_encode_directed();
    send_word(OpEncode, '1, 32'h0000_0000);
    send_word(OpEncode, '0, 32'hFFFF_FFFF);
    send_word(OpEncode, '0, 32'h7FFF_FFFF);
    send_word(OpEncode, '0, 32'h8000_0000);
    send_word(OpEncode, '0, 32'h7FFF_00FF);
    send_word(OpEncode, '0, 32'hA5A5_5A5A);
  endtask

  // The sender pauses with results in flight, then picks up again.
  task automatic test_sender_pause();
    send_word(OpEncode, '0, $urandom());
    send_word(OpDecode, text_letters("ZELGITYE"), '0);
    wait_drained();
    send_word(OpEncode, '0, $urandom());
  endtask

  // Random mix: mostly well-formed codes, some with one bad letter, some pure
  // noise, and encode words, part of them decoded back.
  task automatic test_random_mix(input int unsigned count);
    letters_t    l;
    result_t     enc;
    logic [31:0] word;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 8;
      pick     = $urandom_range(99);
      word     = $urandom();
      if (pick < 35) begin
        for (int i = 0; i < 8; i++) l[i] = any_case_letter(4'($urandom_range(15)));
        send_word(OpDecode, l, word);
      end else if (pick < 45) begin
        for (int i = 0; i < 8; i++) l[i] = any_case_letter(4'($urandom_range(15)));
        l[3'($urandom_range(7))] = 8'($urandom_range(255));
        send_word(OpDecode, l, word);
      end else if (pick < 55) begin
        for (int i = 0; i < 8; i++) l[i] = 8'($urandom_range(255));
        send_word(OpDecode, l, word);
      end else if (pick < 65) begin
        enc = predict_codec(OpEncode, '0, word);
        send_word(OpEncode, {$urandom(), $urandom()}, word);
        send_word(OpDecode, enc.chars, $urandom());
      end else begin
        for (int i = 0; i < 8; i++) l[i] = 8'($urandom_range(255));
        send_word(OpEncode, l, word);
      end
    end
  endtask

  // Matches each result word against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    result_t  expd;
    letters_t got_chars;
    if (rst_ni && done_o) begin
      got_chars = {out_char_7_o, out_char_6_o, out_char_5_o, out_char_4_o,
                   out_char_3_o, out_char_2_o, out_char_1_o, out_char_0_o};
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected", $time);
        mismatch_count++;
      end else begin
        expd = pending_results.pop_front();
        results_checked++;
        if (packed_out_o !== expd.packed_word) begin
          $display("%0t: packed_out expected %h actual %h", $time, expd.packed_word,
                   packed_out_o);
          mismatch_count++;
        end
        for (int i = 0; i < 8; i++) begin
          if (got_chars[i] !== expd.chars[i]) begin
            $display("%0t: out_char_%0d expected %h actual %h", $time, i, expd.chars[i],
                     got_chars[i]);
            mismatch_count++;
          end
        end
        if (code_length_o !== expd.code_length) begin
          $display("%0t: code_length expected %0d actual %0d", $time, expd.code_length,
                   code_length_o);
          mismatch_count++;
        end
        if (error_o !== expd.error) begin
          $display("%0t: error expected %b actual %b", $time, expd.error, error_o);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    op_i        = OpDecode;
    in_char_0_i = '0;
    in_char_1_i = '0;
    in_char_2_i = '0;
    in_char_3_i = '0;
    in_char_4_i = '0;
    in_char_5_i = '0;
    in_char_6_i = '0;
    in_char_7_i = '0;
    packed_in_i = '0;
    idle_pct    = 8;
    mismatch_count  = 0;
    results_checked = 0;
    decode_words    = 0;
    encode_words    = 0;
    long_words      = 0;
    bad_words       = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_decode_directed();
    test_encode_directed();
    test_sender_pause();
    test_random_mix(1450);

    wait_drained();
    $display("Ran %0d decode and %0d encode words: %0d long-form, %0d with bad letters.",
             decode_words, encode_words, long_words, bad_words);
    $display("Checked %0d result words, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
